[rtl/core/kvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table package
// Sizes, codes and shared types of the key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

   localparam int DEPTH      = 64;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int CMP_BITS   = CNT_BITS + 1;
   localparam int ENTRY_BITS = 7;

   localparam logic [1:0] OP_SET = 2'd0;
   localparam logic [1:0] OP_GET = 2'd1;
   localparam logic [1:0] OP_DEL = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISSING  = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      CLS_SET,
      CLS_GET,
      CLS_DEL,
      CLS_NOP
   } cls_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_MISS,
      S_SHIFT_RD,
      S_SHIFT_WR
   } engine_state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] key;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
      logic [ENTRY_BITS-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      cls_type                cls;
      logic [KEY_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]  value;
   } entry_type;

endpackage

[rtl/core/kvt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table front end
// Takes requests, decodes the opcode into a command class and holds up to
// two commands for the engine.
// ----------------------------------------------------------------------------
module kvt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  kvt_pkg::req_type req_item,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output kvt_pkg::cmd_type cmd
);

   kvt_pkg::cmd_type entries_ff [2];
   kvt_pkg::cmd_type new_cmd;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push_ok;

   always_comb begin
      new_cmd.key   = req_item.key[kvt_pkg::KEY_BITS-1:0];
      new_cmd.value = req_item.value_in[kvt_pkg::VALUE_BITS-1:0];
      unique case (req_item.opcode)
         kvt_pkg::OP_SET: new_cmd.cls = kvt_pkg::CLS_SET;
         kvt_pkg::OP_GET: new_cmd.cls = kvt_pkg::CLS_GET;
         kvt_pkg::OP_DEL: new_cmd.cls = kvt_pkg::CLS_DEL;
         default:         new_cmd.cls = kvt_pkg::CLS_NOP;
      endcase
   end

   assign full      = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = entries_ff[rd_ptr_ff];
   assign push_ok   = push & ~full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      fill_in   = fill_ff;
      if (push_ok && !cmd_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!push_ok && cmd_pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

[rtl/core/kvt_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table engine
// Runs one command at a time against the entry memory: a linear search,
// then a read-out, an update, an append or a shift-down, and posts the response.
// ----------------------------------------------------------------------------
module kvt_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  kvt_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_pop,
   output kvt_pkg::rsp_type rsp_item
);

   kvt_pkg::entry_type mem [kvt_pkg::DEPTH];
   kvt_pkg::entry_type rd_data_ff;
   kvt_pkg::entry_type wr_data;
   logic                          mem_we;
   logic [kvt_pkg::IDX_BITS-1:0]  wr_addr;
   logic [kvt_pkg::IDX_BITS-1:0]  rd_addr;

   kvt_pkg::engine_state_type     state_ff, state_in;
   kvt_pkg::cmd_type              cmd_ff, cmd_in;
   logic [kvt_pkg::IDX_BITS-1:0]  idx_ff, idx_in;
   logic [kvt_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   kvt_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          finish;
   logic [1:0]                    fin_status;
   logic [31:0]                   fin_vout;
   logic [kvt_pkg::CMP_BITS-1:0]  idx_w;
   logic [kvt_pkg::CMP_BITS-1:0]  cnt_w;

   assign idx_w     = kvt_pkg::CMP_BITS'(idx_ff);
   assign cnt_w     = kvt_pkg::CMP_BITS'(count_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_pop;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '{key: cmd_ff.key, value: cmd_ff.value};
      rd_addr      = idx_ff;
      finish       = 1'b0;
      fin_status   = kvt_pkg::STATUS_OK;
      fin_vout     = 32'd0;

      unique case (state_ff)
         kvt_pkg::S_IDLE: begin
            // A new command starts only once the response register is free.
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               idx_in  = '0;
               if (cmd.cls == kvt_pkg::CLS_NOP) begin
                  finish = 1'b1;
               end else if (count_ff == '0) begin
                  state_in = kvt_pkg::S_MISS;
               end else begin
                  state_in = kvt_pkg::S_READ;
               end
            end
         end
         kvt_pkg::S_READ: begin
            state_in = kvt_pkg::S_CMP;
         end
         kvt_pkg::S_CMP: begin
            if (rd_data_ff.key == cmd_ff.key) begin
               unique case (cmd_ff.cls)
                  kvt_pkg::CLS_SET: begin
                     mem_we = 1'b1;
                     finish = 1'b1;
                  end
                  kvt_pkg::CLS_GET: begin
                     fin_vout = 32'(rd_data_ff.value);
                     finish   = 1'b1;
                  end
                  kvt_pkg::CLS_DEL: begin
                     if (idx_w + kvt_pkg::CMP_BITS'(1) < cnt_w) begin
                        state_in = kvt_pkg::S_SHIFT_RD;
                     end else begin
                        count_in = count_ff - kvt_pkg::CNT_BITS'(1);
                        finish   = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end else if (idx_w + kvt_pkg::CMP_BITS'(1) == cnt_w) begin
               state_in = kvt_pkg::S_MISS;
            end else begin
               idx_in   = idx_ff + kvt_pkg::IDX_BITS'(1);
               state_in = kvt_pkg::S_READ;
            end
         end
         kvt_pkg::S_MISS: begin
            finish = 1'b1;
            if (cmd_ff.cls == kvt_pkg::CLS_SET) begin
               if (cnt_w < kvt_pkg::CMP_BITS'(kvt_pkg::DEPTH)) begin
                  mem_we   = 1'b1;
                  wr_addr  = count_ff[kvt_pkg::IDX_BITS-1:0];
                  count_in = count_ff + kvt_pkg::CNT_BITS'(1);
               end else begin
                  fin_status = kvt_pkg::STATUS_FULL;
               end
            end else begin
               fin_status = kvt_pkg::STATUS_MISSING;
            end
         end
         kvt_pkg::S_SHIFT_RD: begin
            rd_addr  = idx_ff + kvt_pkg::IDX_BITS'(1);
            state_in = kvt_pkg::S_SHIFT_WR;
         end
         kvt_pkg::S_SHIFT_WR: begin
            // Move the entry above the gap down by one slot.
            mem_we  = 1'b1;
            wr_data = rd_data_ff;
            idx_in  = idx_ff + kvt_pkg::IDX_BITS'(1);
            if (idx_w + kvt_pkg::CMP_BITS'(2) < cnt_w) begin
               state_in = kvt_pkg::S_SHIFT_RD;
            end else begin
               count_in = count_ff - kvt_pkg::CNT_BITS'(1);
               finish   = 1'b1;
            end
         end
         default: begin
            state_in = kvt_pkg::S_IDLE;
         end
      endcase

      if (finish) begin
         state_in            = kvt_pkg::S_IDLE;
         rsp_valid_in        = 1'b1;
         rsp_in.status       = fin_status;
         rsp_in.value_out    = fin_vout;
         rsp_in.entry_count  = kvt_pkg::ENTRY_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvt_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

[rtl/core/key_value_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table
// An associative table of up to 64 unique keys in insertion order.
//
// Requests enter through push/full with req_item carrying opcode, key and
// value_in. Responses leave through empty/pop; rsp_item holds status,
// value_out and the entry count after the request.
// A front queue of two requests decouples the request side from the engine,
// so requests are taken while a response waits to be popped.
// The engine searches the entry memory one entry at a time (address, then
// compare against the registered read data). A response waits longer the
// more entries are compared, and a remove also shifts down each entry above
// the removed one; the wait is longest when a full table is searched without
// a hit, as for a set that finds no room.
// Requests with an unused opcode finish without a search.
// Reset empties the table and both queues; the memory is not cleared, since
// only entries below the entry count are ever read.
// When the receiver holds off pop, the engine waits after one response and
// up to two more requests are queued, then full rises.
// ----------------------------------------------------------------------------
module key_value_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  kvt_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output kvt_pkg::rsp_type rsp_item
);

   logic             cmd_valid;
   logic             cmd_pop;
   kvt_pkg::cmd_type cmd;
   logic             rsp_valid;

   kvt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   kvt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_pop   (pop & rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign empty = ~rsp_valid;

endmodule

[rtl/core/kvt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table checker
// Port-level checks of the key/value table, bound to the top level.
// ----------------------------------------------------------------------------
module kvt_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input kvt_pkg::rsp_type rsp_item
);

   // Reset leaves no response pending and room for requests.
   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   // A response that is not popped stays put.
   assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_item))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_item.status != kvt_pkg::STATUS_RESERVED)
      else $error("reserved status code");

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_item.entry_count <= kvt_pkg::ENTRY_BITS'(kvt_pkg::DEPTH))
      else $error("entry count above table depth");

   // Only a found lookup returns a value.
   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item.status != kvt_pkg::STATUS_OK |-> rsp_item.value_out == 32'd0)
      else $error("value returned with a failing status");

endmodule

bind key_value_table kvt_checker u_checker (.*);
